// File: hdl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// Point distance dedup package
// Constants shared by the dedup core and its configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package pdd_pkg;

  // Squared radius register width.
  localparam int RADIUS_W = 40;

  // Configuration port: one register on a 64-bit data bus; the core does not decode paddr.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 3;

  typedef logic [RADIUS_W-1:0] radius_t;

endpackage

`default_nettype wire

// File: hdl/point_distance_dedup_core.sv
// ----------------------------------------------------------------------------
// Point distance dedup core
// Greedy radius deduplication of a 2-D point stream against the points kept
// so far in the current list.
// ----------------------------------------------------------------------------
// A point is taken when start is high and busy is low. The core then reads
// every stored point of the current list from its point RAM, one per clock,
// through a three-stage distance pipeline (difference, square, sum and
// compare). The result strobe follows the finishing state, which is reached
// once the pipeline has drained, or directly from idle when the store is
// empty; busy drops in the same cycle as the strobe. A kept point is
// appended to the store while there is room; the store empties after the
// point marked list_end. Results are shown for exactly one cycle on
// out_valid and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module point_distance_dedup_core #(
  parameter int STORE_DEPTH = 64,
  parameter int COORD_BITS  = 18
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input channel
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic signed [COORD_BITS-1:0]        in_point_x,
  input  wire logic signed [COORD_BITS-1:0]        in_point_y,
  input  wire logic                                in_list_end,
  // Result channel
  output logic                                     out_valid,
  output logic                                     out_keep,
  output logic signed [COORD_BITS-1:0]             out_x,
  output logic signed [COORD_BITS-1:0]             out_y,
  output logic                                     out_end,
  output logic                                     out_store_overflow,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [pdd_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [pdd_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic      [pdd_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                     pready
);

  import pdd_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int CW    = $clog2(STORE_DEPTH + 1);
  localparam int MAG_W = COORD_BITS + 1;
  localparam int SQ_W  = 2 * MAG_W;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > RADIUS_W) ? SUM_W : RADIUS_W;
  localparam int MEM_W = 2 * COORD_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  // Control state
  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [CW-1:0] kept_count_r, kept_count_nxt;
  logic          near_r, near_nxt;
  logic          v0_r, v1_r, v2_r;
  logic          out_valid_r;
  radius_t       radius_r;

  // Payload
  logic signed [COORD_BITS-1:0] px_r, py_r;
  logic                         end_r;
  logic        [MAG_W-1:0]      dx_r, dy_r;
  logic        [SQ_W-1:0]       sqx_r, sqy_r;
  logic                         keep_r, ovf_r;
  logic signed [COORD_BITS-1:0] ox_r, oy_r;
  logic                         oend_r;

  // RAM interface
  logic             mem_we, mem_re;
  logic [MEM_W-1:0] mem_rdata;

  logic accept, cfg_wr, last_read, store_full, is_near;
  logic signed [COORD_BITS-1:0] kx, ky;
  logic signed [MAG_W-1:0]      diff_x, diff_y;

  assign accept     = start && !busy;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign busy       = (state_r != ST_IDLE);
  assign pready     = 1'b1;
  assign prdata     = CFG_DATA_W'(radius_r);
  assign last_read  = (CW'(addr_r) + CW'(1)) == kept_count_r;
  assign store_full = (kept_count_r == CW'(STORE_DEPTH));

  // Reads and writes never overlap: the append happens only after the scan
  // pipeline has drained, and the next scan starts after it.
  assign mem_re = (state_r == ST_SCAN);
  assign mem_we = (state_r == ST_FINISH) && !near_r && !store_full;

  pdd_ram #(
    .WIDTH (MEM_W),
    .DEPTH (STORE_DEPTH)
  ) u_point_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (kept_count_r[AW-1:0]),
    .wdata ({px_r, py_r}),
    .re    (mem_re),
    .raddr (addr_r),
    .rdata (mem_rdata)
  );

  assign kx     = mem_rdata[MEM_W-1:COORD_BITS];
  assign ky     = mem_rdata[COORD_BITS-1:0];
  assign diff_x = MAG_W'(px_r) - MAG_W'(kx);
  assign diff_y = MAG_W'(py_r) - MAG_W'(ky);
  assign is_near = (CMP_W'(sqx_r) + CMP_W'(sqy_r)) <= CMP_W'(radius_r);

  always_comb begin
    state_nxt      = state_r;
    addr_nxt       = addr_r;
    kept_count_nxt = kept_count_r;
    near_nxt       = near_r;
    if (v2_r && is_near) begin
      near_nxt = 1'b1;
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          addr_nxt  = '0;
          near_nxt  = 1'b0;
          state_nxt = (kept_count_r == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        addr_nxt = addr_r + AW'(1);
        if (last_read) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v0_r && !v1_r && !v2_r) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (mem_we) begin
          kept_count_nxt = kept_count_r + CW'(1);
        end
        if (end_r) begin
          kept_count_nxt = '0;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      addr_r       <= '0;
      kept_count_r <= '0;
      near_r       <= 1'b0;
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
      radius_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      addr_r       <= addr_nxt;
      kept_count_r <= kept_count_nxt;
      near_r       <= near_nxt;
      v0_r         <= mem_re;
      v1_r         <= v0_r;
      v2_r         <= v1_r;
      out_valid_r  <= (state_r == ST_FINISH);
      if (cfg_wr) begin
        radius_r <= pwdata[RADIUS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px_r  <= in_point_x;
      py_r  <= in_point_y;
      end_r <= in_list_end;
    end
    // Distance pipeline: absolute differences, then squares.
    dx_r  <= diff_x[MAG_W-1] ? MAG_W'(-diff_x) : MAG_W'(diff_x);
    dy_r  <= diff_y[MAG_W-1] ? MAG_W'(-diff_y) : MAG_W'(diff_y);
    sqx_r <= SQ_W'(dx_r) * SQ_W'(dx_r);
    sqy_r <= SQ_W'(dy_r) * SQ_W'(dy_r);
    if (state_r == ST_FINISH) begin
      keep_r <= !near_r;
      ovf_r  <= !near_r && store_full;
      ox_r   <= px_r;
      oy_r   <= py_r;
      oend_r <= end_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_keep           = keep_r;
  assign out_x              = ox_r;
  assign out_y              = oy_r;
  assign out_end            = oend_r;
  assign out_store_overflow = ovf_r;

  // A result strobe follows exactly one cycle of the finishing state.
  a_strobe_after_finish : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FINISH))
    else $error("result strobe without a finished point");

  // Overflow is only reported for a point that is kept.
  a_overflow_kept : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_store_overflow) |-> out_keep)
    else $error("overflow on a dropped point");

  // The store count never passes the depth.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    kept_count_r <= CW'(STORE_DEPTH))
    else $error("store count beyond depth");

  // No append while distance reads are still in flight.
  a_no_write_in_scan : assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (!v0_r && !v1_r && !v2_r && !mem_re))
    else $error("store write overlaps the scan");

endmodule

`default_nettype wire

// File: hdl/pdd_ram.sv
// ----------------------------------------------------------------------------
// Point distance dedup RAM
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read, no reset on the contents.
// ----------------------------------------------------------------------------
`default_nettype none

module pdd_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: verif/point_distance_dedup_core_test.sv
// ----------------------------------------------------------------------------
// Point distance dedup core testbench
// Sends point lists through the command-style input channel and checks every
// result strobe against a cycle-free model of greedy radius deduplication.
// Directed tests cover coordinate extremes, the radius boundary, the full
// store and the list end. They are followed by random lists under several
// radius settings, which are written over the APB port and read back.
// ----------------------------------------------------------------------------
`default_nettype none

module point_distance_dedup_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pdd_pkg::*;

  localparam int     DEPTH        = 64;
  localparam int     CW           = 18;
  localparam logic [CFG_ADDR_W-1:0] RADIUS_ADDR = '0;
  localparam longint CYCLE_LIMIT  = 1000000;
  localparam int     DRAIN_CYCLES = DEPTH + 16;
  localparam int     MAX_REPORTS  = 50;
  localparam int     RANDOM_ITEMS = 1500;

  typedef logic signed [CW-1:0] coord_t;

  localparam coord_t coord_min = coord_t'(-131072);
  localparam coord_t coord_max = coord_t'(131071);

  typedef struct packed {
    logic   keep;
    coord_t x;
    coord_t y;
    logic   last;
    logic   overflow;
  } dedup_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  coord_t                in_point_x;
  coord_t                in_point_y;
  logic                  in_list_end;
  logic                  out_valid;
  logic                  out_keep;
  coord_t                out_x;
  coord_t                out_y;
  logic                  out_end;
  logic                  out_store_overflow;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  point_distance_dedup_core #(
    .STORE_DEPTH(DEPTH),
    .COORD_BITS (CW)
  ) i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_list_end       (in_list_end),
    .out_valid         (out_valid),
    .out_keep          (out_keep),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_end           (out_end),
    .out_store_overflow(out_store_overflow),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Model of the kept-point store. Coordinates are held with the sign bit
  // flipped so that unsigned differences give the true distance.
  radius_t         model_radius;
  logic [CW-1:0]   kept_x [DEPTH];
  logic [CW-1:0]   kept_y [DEPTH];
  int              kept_total;
  dedup_result_t   pending_results[$];
  int              error_count;
  longint          cycle_count;
  bit              idle_enable;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic dedup_result_t predict_dedup(coord_t px, coord_t py, logic last);
    logic [CW-1:0] bx;
    logic [CW-1:0] by;
    logic [63:0]   dx;
    logic [63:0]   dy;
    logic          near;
    dedup_result_t res;
    bx = {~px[CW-1], px[CW-2:0]};
    by = {~py[CW-1], py[CW-2:0]};
    near = 1'b0;
    for (int i = 0; i < kept_total && !near; i++) begin
      dx = (bx > kept_x[i]) ? 64'(bx - kept_x[i]) : 64'(kept_x[i] - bx);
      dy = (by > kept_y[i]) ? 64'(by - kept_y[i]) : 64'(kept_y[i] - by);
      if (dx * dx + dy * dy <= 64'(model_radius)) near = 1'b1;
    end
    res.keep = !near;
    res.overflow = 1'b0;
    if (!near) begin
      if (kept_total < DEPTH) begin
        kept_x[kept_total] = bx;
        kept_y[kept_total] = by;
        kept_total++;
      end else begin
        res.overflow = 1'b1;
      end
    end
    if (last) kept_total = 0;
    res.x = px;
    res.y = py;
    res.last = last;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] exp_val, logic [63:0] act_val);
    if (error_count < MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_val, act_val);
    error_count++;
  endtask

  // Results cannot be held off, so each strobe is checked in the middle of
  // its single valid cycle.
  always @(negedge clk) begin : result_check
    dedup_result_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'd0, 64'd1);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_keep !== exp_res.keep)
          report_mismatch("keep", 64'(exp_res.keep), 64'(out_keep));
        if (out_x !== exp_res.x) report_mismatch("out_x", 64'(exp_res.x), 64'(out_x));
        if (out_y !== exp_res.y) report_mismatch("out_y", 64'(exp_res.y), 64'(out_y));
        if (out_end !== exp_res.last)
          report_mismatch("out_end", 64'(exp_res.last), 64'(out_end));
        if (out_store_overflow !== exp_res.overflow)
          report_mismatch("store_overflow", 64'(exp_res.overflow), 64'(out_store_overflow));
      end
    end
  end

  // Called at a rising edge; returns at the edge that accepts the point.
  task automatic send_point(coord_t px, coord_t py, logic last);
    int gap;
    gap = idle_enable ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_point_x  <= px;
    in_point_y  <= py;
    in_list_end <= last;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    pending_results.insert(pending_results.size(), predict_dedup(px, py, last));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_radius(logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIUS_ADDR;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    model_radius = value[RADIUS_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    // Read the register back; bits above the radius width are not checked.
    psel    <= 1'b1;
    paddr   <= RADIUS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    if (prdata[RADIUS_W-1:0] !== model_radius)
      report_mismatch("radius readback", 64'(model_radius), 64'(prdata[RADIUS_W-1:0]));
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_zero_radius();
    idle_enable = 1'b1;
    send_point(coord_t'(0), coord_t'(0), 1'b0);
    send_point(coord_t'(0), coord_t'(0), 1'b0);
    send_point(coord_t'(1), coord_t'(0), 1'b0);
    send_point(coord_t'(0), coord_t'(1), 1'b0);
    send_point(coord_min, coord_min, 1'b0);
    send_point(coord_max, coord_max, 1'b0);
    send_point(coord_min, coord_max, 1'b0);
    send_point(coord_max, coord_min, 1'b0);
    send_point(coord_min, coord_min, 1'b1);
    // The store is empty again, so the same point is kept.
    send_point(coord_min, coord_min, 1'b0);
    send_point(coord_t'(-1), coord_t'(-1), 1'b1);
    wait_drained();
  endtask

  task automatic test_radius_boundary();
    logic [63:0] corner_dist;
    corner_dist = 2 * 64'(262143) * 64'(262143);
    set_radius(64'(25));
    send_point(coord_t'(0), coord_t'(0), 1'b0);
    send_point(coord_t'(3), coord_t'(4), 1'b0);
    send_point(coord_t'(-3), coord_t'(-4), 1'b0);
    send_point(coord_t'(5), coord_t'(1), 1'b1);
    wait_drained();
    set_radius(corner_dist - 1);
    send_point(coord_min, coord_min, 1'b0);
    send_point(coord_max, coord_max, 1'b1);
    wait_drained();
    set_radius(corner_dist);
    send_point(coord_min, coord_min, 1'b0);
    send_point(coord_max, coord_max, 1'b1);
    wait_drained();
    // Bits above the register width must be ignored.
    set_radius(64'hFFFF_FFFF_FFFF_FFFF);
    send_point(coord_max, coord_min, 1'b0);
    send_point(coord_min, coord_max, 1'b0);
    send_point(coord_t'(0), coord_t'(0), 1'b1);
    wait_drained();
  endtask

  task automatic test_store_full();
    set_radius(64'(0));
    idle_enable = 1'b0;
    for (int i = 0; i < DEPTH; i++) send_point(coord_t'(i * 3), coord_t'(-i * 5), 1'b0);
    send_point(coord_t'(7), coord_t'(7), 1'b0);
    send_point(coord_t'(-7), coord_t'(7), 1'b0);
    // A duplicate of a stored point is dropped; a repeat of an unstored one
    // is kept again with the overflow flag.
    send_point(coord_t'(3), coord_t'(-5), 1'b0);
    send_point(coord_t'(7), coord_t'(7), 1'b1);
    send_point(coord_t'(7), coord_t'(7), 1'b1);
    wait_drained();
  endtask

  task automatic test_random_lists();
    int          sent;
    int          phase;
    int          list_len;
    int          spread;
    int          cx;
    int          cy;
    logic [63:0] radius_value;
    int          root;
    coord_t      px;
    coord_t      py;
    logic        last;
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase == 0 ? 0 : phase == 1 ? 1 : $urandom_range(0, 5))
        0: radius_value = '0;
        1: radius_value = {$urandom, $urandom};
        2: radius_value = 64'($urandom_range(0, 64));
        3: begin
          root = $urandom_range(1, 4000);
          radius_value = 64'(root) * 64'(root);
        end
        4: radius_value = {24'(0), 8'($urandom), 32'($urandom)};
        default: begin
          root = $urandom_range(1, 100000);
          radius_value = 64'(root) * 64'(root);
        end
      endcase
      set_radius(radius_value);
      idle_enable = ($urandom_range(0, 3) != 0);
      for (int item = 0; item < 150; item += list_len) begin
        list_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 80)
                                                : $urandom_range(1, 20);
        case ($urandom_range(0, 3))
          0: spread = 8;
          1: spread = 256;
          2: spread = 8192;
          default: spread = 0;
        endcase
        cx = $urandom_range(0, 262143) - 131072;
        cy = $urandom_range(0, 262143) - 131072;
        for (int n = 0; n < list_len; n++) begin
          if (spread == 0) begin
            px = coord_t'($urandom);
            py = coord_t'($urandom);
          end else begin
            px = coord_t'(cx + $urandom_range(0, 2 * spread) - spread);
            py = coord_t'(cy + $urandom_range(0, 2 * spread) - spread);
          end
          // Now and then a list is cut short by an early end marker.
          last = (n == list_len - 1) || ($urandom_range(0, 39) == 0);
          send_point(px, py, last);
          sent++;
        end
      end
      wait_drained();
      phase++;
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_point_x  <= '0;
    in_point_y  <= '0;
    in_list_end <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    cycle_count <= 0;
    error_count = 0;
    model_radius = '0;
    kept_total = 0;
    idle_enable = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      kept_x[i] = '0;
      kept_y[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_radius();
    test_radius_boundary();
    test_store_full();
    test_random_lists();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d results never arrived", $time, pending_results.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
